FILE: rtl/ggw_pkg.sv
`timescale 1ns / 1ps

package ggw_pkg;

  localparam logic [7:0] LINE_BREAK = 8'd10;
  localparam logic [7:0] SPACE_CHAR = 8'd32;
  localparam logic [7:0] TAB_CHAR   = 8'd9;
  localparam logic [7:0] CR_CHAR    = 8'd13;
  localparam logic [7:0] COL_RESET  = 8'd80;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_BRK  = 4'b0010,
    ST_WORD = 4'b0100,
    ST_WS   = 4'b1000
  } ggw_state_t;

  typedef struct packed {
    logic load;
    logic shift;
  } ggw_cell_ctl_t;

  function automatic logic is_blank(input logic [7:0] ch);
    is_blank = ((ch >= TAB_CHAR) && (ch <= CR_CHAR)) || (ch == SPACE_CHAR);
  endfunction

endpackage

FILE: rtl/greedy_word_wrap_core.sv
`timescale 1ns / 1ps

// Channel  | Ports              | Beat contents
// ---------+--------------------+---------------------------------------------
// input    | in_tvalid/tready   | tdata: in_char; tlast: text_end
// output   | out_tvalid/tready  | tdata: out_char; tlast: run_end; tuser: word_cut
// config   | cfg_we, cfg_wdata  | wrap_width, taken on any edge with cfg_we high outside reset
//
// A non-whitespace byte that is not the last is taken while idle and starts no flush.
// A flush emits, in order, an optional line break, the stored word bytes
// and an optional whitespace byte; the cell chain shifts one byte toward
// the output register per cycle while the output is not stalled.
// Synchronous active-low reset clears word and line lengths and state, and sets column width to 80.
// An output stall holds the flush; new bytes are taken only when idle.

module greedy_word_wrap_core #(
  parameter int MAX_WORD = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_char
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tlast,
  output logic       out_tuser,  // [0] word_cut
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  localparam int WL_W = $clog2(MAX_WORD + 1);

  ggw_pkg::ggw_state_t state_r, state_nxt;
  logic [WL_W-1:0] word_len_r, word_len_nxt;
  logic [7:0]      line_len_r, line_len_nxt;
  logic            word_ovf_r, word_ovf_nxt;
  logic [7:0]      col_width_r;
  logic [WL_W-1:0] cnt_r, cnt_nxt;
  logic            ext_r, ext_nxt;
  logic            cut_r, cut_nxt;
  logic [7:0]      ws_char_r, ws_char_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_char_r, out_char_nxt;
  logic            out_last_r, out_last_nxt;
  logic            out_cut_r, out_cut_nxt;

  logic            in_acc, blank, room, store, flush, out_free, shift_en, brk;
  logic [WL_W-1:0] wl_eff;
  logic            ovf_eff;
  logic [8:0]      test_sum, base_sum;
  logic [7:0]      new_line;

  ggw_pkg::ggw_cell_ctl_t cell_ctl [MAX_WORD];
  logic [7:0]             cell_q   [MAX_WORD];

  assign in_tready = (state_r == ggw_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign blank     = ggw_pkg::is_blank(in_tdata);
  assign room      = word_len_r < WL_W'(MAX_WORD);
  assign store     = in_acc && !blank && room;
  assign wl_eff    = store ? word_len_r + WL_W'(1) : word_len_r;
  assign ovf_eff   = word_ovf_r || (in_acc && !blank && !room);
  assign flush     = in_acc && (blank || in_tlast);
  assign out_free  = !out_valid_r || out_tready;

  assign test_sum = {1'b0, line_len_r} + 9'(wl_eff) + 9'(blank);
  assign brk      = test_sum > {1'b0, col_width_r};
  assign base_sum = (brk ? 9'd0 : {1'b0, line_len_r}) + 9'(wl_eff) + 9'(blank);
  assign new_line = base_sum[8] ? 8'hFF : base_sum[7:0];

  genvar gi;
  generate
    for (gi = 0; gi < MAX_WORD; gi++) begin : g_cell
      logic [7:0] right_d;
      if (gi < MAX_WORD - 1) begin : g_mid
        assign right_d = cell_q[gi+1];
      end else begin : g_end
        assign right_d = cell_q[gi];
      end
      assign cell_ctl[gi].load  = store && (word_len_r == WL_W'(gi));
      assign cell_ctl[gi].shift = shift_en;
      ggw_cell u_cell (
        .clk        (clk),
        .ctl        (cell_ctl[gi]),
        .load_data  (in_tdata),
        .right_data (right_d),
        .data       (cell_q[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    word_len_nxt  = word_len_r;
    line_len_nxt  = line_len_r;
    word_ovf_nxt  = word_ovf_r;
    cnt_nxt       = cnt_r;
    ext_nxt       = ext_r;
    cut_nxt       = cut_r;
    ws_char_nxt   = ws_char_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_cut_nxt   = out_cut_r;
    shift_en      = 1'b0;
    case (state_r)
      ggw_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (flush) begin
            word_len_nxt = '0;
            word_ovf_nxt = 1'b0;
            line_len_nxt = in_tlast ? 8'd0 : new_line;
            cnt_nxt      = wl_eff;
            ext_nxt      = blank;
            cut_nxt      = ovf_eff;
            ws_char_nxt  = in_tdata;
            if (brk) begin
              state_nxt = ggw_pkg::ST_BRK;
            end else if (wl_eff != '0) begin
              state_nxt = ggw_pkg::ST_WORD;
            end else if (blank) begin
              state_nxt = ggw_pkg::ST_WS;
            end
          end else begin
            word_len_nxt = wl_eff;
            word_ovf_nxt = ovf_eff;
          end
        end
      end
      ggw_pkg::ST_BRK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ggw_pkg::LINE_BREAK;
          out_cut_nxt   = 1'b0;
          out_last_nxt  = (cnt_r == '0) && !ext_r;
          if (cnt_r != '0) begin
            state_nxt = ggw_pkg::ST_WORD;
          end else if (ext_r) begin
            state_nxt = ggw_pkg::ST_WS;
          end else begin
            state_nxt = ggw_pkg::ST_IDLE;
          end
        end
      end
      ggw_pkg::ST_WORD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = cell_q[0];
          out_cut_nxt   = cut_r;
          out_last_nxt  = (cnt_r == WL_W'(1)) && !ext_r;
          shift_en      = 1'b1;
          cnt_nxt       = cnt_r - WL_W'(1);
          if (cnt_r == WL_W'(1)) begin
            state_nxt = ext_r ? ggw_pkg::ST_WS : ggw_pkg::ST_IDLE;
          end
        end
      end
      ggw_pkg::ST_WS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ws_char_r;
          out_cut_nxt   = 1'b0;
          out_last_nxt  = 1'b1;
          state_nxt     = ggw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ggw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ggw_pkg::ST_IDLE;
      word_len_r  <= '0;
      line_len_r  <= 8'd0;
      word_ovf_r  <= 1'b0;
      col_width_r <= ggw_pkg::COL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      word_len_r  <= word_len_nxt;
      line_len_r  <= line_len_nxt;
      word_ovf_r  <= word_ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        col_width_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    ext_r      <= ext_nxt;
    cut_r      <= cut_nxt;
    ws_char_r  <= ws_char_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_cut_r  <= out_cut_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_cut_r;

  a_word_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ggw_pkg::ST_WORD |-> cnt_r != '0)
    else $error("word state entered with no bytes left");

  a_word_len: assert property (@(posedge clk) disable iff (!rst_n)
    word_len_r <= WL_W'(MAX_WORD))
    else $error("word length beyond store depth");

  a_ws_flush: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && blank |=> state_r != ggw_pkg::ST_IDLE)
    else $error("whitespace beat caused no flush");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ggw_pkg::ST_WS && out_free |=> out_tvalid && out_tlast)
    else $error("whitespace beat not marked as last of run");

endmodule

FILE: rtl/ggw_cell.sv
`timescale 1ns / 1ps

module ggw_cell (
  input  logic                  clk,
  input  ggw_pkg::ggw_cell_ctl_t ctl,
  input  logic [7:0]            load_data,
  input  logic [7:0]            right_data,
  output logic [7:0]            data
);

  logic [7:0] data_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data_r <= load_data;
    end else if (ctl.shift) begin
      data_r <= right_data;
    end
  end

  assign data = data_r;

endmodule
